>>> src/ppts_pkg.sv
// Shared constants for the periodic priority task scheduler.
// No dependencies.
`default_nettype none

package ppts_pkg;

  // command word fields
  localparam int CMD_W  = 2;
  localparam int PER_W  = 16;
  localparam int PREQ_W = 8;
  localparam int PRIO_W = 7;
  localparam int IDX_W  = 4;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE     = 2'd3;

  // highest priority value kept
  localparam logic [PREQ_W-1:0] PRIO_CAP = 8'd127;

endpackage : ppts_pkg

`default_nettype wire

>>> src/ppts_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module ppts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : ppts_ram

`default_nettype wire

>>> src/periodic_priority_task_scheduler.sv
// Top level of the periodic priority task scheduler: control sequencer and
// the period, countdown, priority and queue RAMs. Uses ppts_pkg, ppts_ram.
//
// Usage: a command word (in_cmd, in_period, in_priority_req) is taken at a
// clock edge where start is high and busy is low. Exactly one result word
// follows, shown for one cycle with out_valid high; it cannot be held off.
// An unused command, or a tick with no tasks, is answered from idle; an add
// writes one slot; a tick reads and rewrites the countdown of each task in
// use; a dispatch scans every slot in use, inserts each newly due task into
// the queue by priority, comparing entries and moving later ones up one
// place, then runs the queue head if there is one.
// The rate is set by the single read port of each RAM: each slot and each
// queue entry is visited one read at a time. busy drops with the strobe,
// so the next command may be taken in the strobe cycle.
// Reset clears the task count, the queue length, all due and pending flags
// and the output strobe; RAM contents are written before they are read.
`default_nettype none

module periodic_priority_task_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [ppts_pkg::CMD_W-1:0]   in_cmd,
  input  wire logic [ppts_pkg::PER_W-1:0]   in_period,
  input  wire logic [ppts_pkg::PREQ_W-1:0]  in_priority_req,
  output logic                              out_valid,
  output logic                              out_ran_task,
  output logic      [ppts_pkg::IDX_W-1:0]   out_task_index,
  output logic                              out_table_full
);

  import ppts_pkg::*;

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int AW = CW + 1;
  localparam logic [CW-1:0] NCNT = CW'(MAX_TASKS);
  localparam logic [AW-1:0] NSUM = AW'(MAX_TASKS);

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_ADD      = 14'b00000000000010,
    S_TICK_RD  = 14'b00000000000100,
    S_TICK_WR  = 14'b00000000001000,
    S_SCAN     = 14'b00000000010000,
    S_PRI_WAIT = 14'b00000000100000,
    S_POS_CHK  = 14'b00000001000000,
    S_POS_Q    = 14'b00000010000000,
    S_POS_CMP  = 14'b00000100000000,
    S_SHF      = 14'b00001000000000,
    S_SHF_WR   = 14'b00010000000000,
    S_POP_RD   = 14'b00100000000000,
    S_POP_Q    = 14'b01000000000000,
    S_POP_WR   = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [PER_W-1:0]  per_r, per_nxt;
  logic [PREQ_W-1:0] preq_r, preq_nxt;
  logic [CW-1:0]     tiu_r, tiu_nxt;
  logic [CW-1:0]     qlen_r, qlen_nxt;
  logic [IW-1:0]     qb_r, qb_nxt;
  logic [CW-1:0]     i_r, i_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic [IW-1:0]     s_r, s_nxt;
  logic [PRIO_W-1:0] spri_r, spri_nxt;
  logic              due_r [MAX_TASKS];
  logic              due_nxt [MAX_TASKS];
  logic              pend_r [MAX_TASKS];
  logic              pend_nxt [MAX_TASKS];
  logic              ov_r, ov_nxt;
  logic              oran_r, oran_nxt;
  logic [IDX_W-1:0]  oidx_r, oidx_nxt;
  logic              ofull_r, ofull_nxt;

  // ram ports
  logic              per_we, cnt_we, pri_we, q_we;
  logic [IW-1:0]     per_wa, cnt_wa, pri_wa, q_wa;
  logic [IW-1:0]     per_ra, cnt_ra, pri_ra, q_ra;
  logic [PER_W-1:0]  per_wd, cnt_wd, per_rd, cnt_rd;
  logic [PRIO_W-1:0] pri_wd, pri_rd;
  logic [IW-1:0]     q_wd, q_rd;

  // scratch
  logic [PER_W-1:0]  per_eff;
  logic [PRIO_W-1:0] pri_eff;
  logic [IW-1:0]     slot;
  logic [IW-1:0]     scan_s;
  logic [CW-1:0]     i_dec;

  // ring position of queue entry j
  function automatic logic [IW-1:0] q_addr(input logic [IW-1:0] base, input logic [CW-1:0] j);
    logic [AW-1:0] sum;
    sum = AW'(base) + AW'(j);
    if (sum >= NSUM) begin
      sum = sum - NSUM;
    end
    return sum[IW-1:0];
  endfunction

  ppts_ram #(.WIDTH(PER_W), .DEPTH(MAX_TASKS)) u_per_ram (
    .clk(clk), .we(per_we), .waddr(per_wa), .wdata(per_wd), .raddr(per_ra), .rdata(per_rd)
  );
  ppts_ram #(.WIDTH(PER_W), .DEPTH(MAX_TASKS)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd), .raddr(cnt_ra), .rdata(cnt_rd)
  );
  ppts_ram #(.WIDTH(PRIO_W), .DEPTH(MAX_TASKS)) u_pri_ram (
    .clk(clk), .we(pri_we), .waddr(pri_wa), .wdata(pri_wd), .raddr(pri_ra), .rdata(pri_rd)
  );
  ppts_ram #(.WIDTH(IW), .DEPTH(MAX_TASKS)) u_q_ram (
    .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd)
  );

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = ov_r;
  assign out_ran_task   = oran_r;
  assign out_task_index = oidx_r;
  assign out_table_full = ofull_r;

  // add field cleanup
  assign per_eff = (per_r == '0) ? PER_W'(1) : per_r;
  assign pri_eff = (preq_r > PRIO_CAP) ? PRIO_CAP[PRIO_W-1:0] : preq_r[PRIO_W-1:0];
  assign slot    = tiu_r[IW-1:0];
  assign i_dec   = i_r - CW'(1);
  assign scan_s  = i_dec[IW-1:0];

  // sequencer
  always_comb begin
    state_nxt = state_r;
    per_nxt   = per_r;
    preq_nxt  = preq_r;
    tiu_nxt   = tiu_r;
    qlen_nxt  = qlen_r;
    qb_nxt    = qb_r;
    i_nxt     = i_r;
    pos_nxt   = pos_r;
    k_nxt     = k_r;
    s_nxt     = s_r;
    spri_nxt  = spri_r;
    due_nxt   = due_r;
    pend_nxt  = pend_r;
    ov_nxt    = 1'b0;
    oran_nxt  = oran_r;
    oidx_nxt  = oidx_r;
    ofull_nxt = ofull_r;

    per_we = 1'b0; per_wa = slot; per_wd = per_eff; per_ra = s_r;
    cnt_we = 1'b0; cnt_wa = slot; cnt_wd = per_eff; cnt_ra = i_r[IW-1:0];
    pri_we = 1'b0; pri_wa = slot; pri_wd = pri_eff; pri_ra = scan_s;
    q_we   = 1'b0; q_wa   = q_addr(qb_r, pos_r); q_wd = s_r; q_ra = qb_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          per_nxt  = in_period;
          preq_nxt = in_priority_req;
          i_nxt    = '0;
          unique case (in_cmd)
            CMD_ADD:      state_nxt = S_ADD;
            CMD_TICK: begin
              if (tiu_r == '0) begin
                ov_nxt = 1'b1; oran_nxt = 1'b0; oidx_nxt = '0; ofull_nxt = 1'b0;
              end else begin
                state_nxt = S_TICK_RD;
              end
            end
            CMD_DISPATCH: begin
              i_nxt     = tiu_r;
              state_nxt = S_SCAN;
            end
            default: begin
              ov_nxt = 1'b1; oran_nxt = 1'b0; oidx_nxt = '0; ofull_nxt = 1'b0;
            end
          endcase
        end
      end

      // register a new task or report a full table
      S_ADD: begin
        ov_nxt    = 1'b1;
        oran_nxt  = 1'b0;
        state_nxt = S_IDLE;
        if (tiu_r == NCNT) begin
          oidx_nxt  = '0;
          ofull_nxt = 1'b1;
        end else begin
          per_we = 1'b1;
          cnt_we = 1'b1;
          pri_we = 1'b1;
          due_nxt[slot]  = 1'b0;
          pend_nxt[slot] = 1'b0;
          tiu_nxt   = tiu_r + CW'(1);
          oidx_nxt  = IDX_W'(slot);
          ofull_nxt = 1'b0;
        end
      end

      // tick: read each countdown, then write it back decremented unless zero
      S_TICK_RD: state_nxt = S_TICK_WR;

      S_TICK_WR: begin
        cnt_wa = i_r[IW-1:0];
        cnt_wd = cnt_rd - PER_W'(1);
        if (cnt_rd != '0) begin
          cnt_we = 1'b1;
          if (cnt_rd == PER_W'(1)) begin
            due_nxt[i_r[IW-1:0]] = 1'b1;
          end
        end
        i_nxt = i_r + CW'(1);
        if (i_r + CW'(1) == tiu_r) begin
          ov_nxt = 1'b1; oran_nxt = 1'b0; oidx_nxt = '0; ofull_nxt = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_TICK_RD;
        end
      end

      // scan slots newest to oldest for due tasks not yet queued
      S_SCAN: begin
        if (i_r == '0) begin
          state_nxt = S_POP_RD;
        end else if (due_r[scan_s] && !pend_r[scan_s]) begin
          s_nxt = scan_s;
          due_nxt[scan_s] = 1'b0;
          if (qlen_r == '0) begin
            q_we = 1'b1;
            q_wa = qb_r;
            q_wd = scan_s;
            qlen_nxt = CW'(1);
            pend_nxt[scan_s] = 1'b1;
            i_nxt = i_dec;
          end else begin
            state_nxt = S_PRI_WAIT;
          end
        end else begin
          i_nxt = i_dec;
        end
      end

      S_PRI_WAIT: begin
        spri_nxt  = pri_rd;
        pos_nxt   = CW'(1);
        state_nxt = S_POS_CHK;
      end

      // find the first later entry with a strictly greater priority
      S_POS_CHK: begin
        if (pos_r == qlen_r) begin
          k_nxt     = qlen_r;
          state_nxt = S_SHF;
        end else begin
          q_ra      = q_addr(qb_r, pos_r);
          state_nxt = S_POS_Q;
        end
      end

      S_POS_Q: begin
        pri_ra    = q_rd;
        state_nxt = S_POS_CMP;
      end

      S_POS_CMP: begin
        if (spri_r < pri_rd) begin
          k_nxt     = qlen_r;
          state_nxt = S_SHF;
        end else begin
          pos_nxt   = pos_r + CW'(1);
          state_nxt = S_POS_CHK;
        end
      end

      // move entries up one place, then drop the task in
      S_SHF: begin
        if (k_r == pos_r) begin
          q_we = 1'b1;
          q_wa = q_addr(qb_r, pos_r);
          q_wd = s_r;
          qlen_nxt = qlen_r + CW'(1);
          pend_nxt[s_r] = 1'b1;
          i_nxt = i_dec;
          state_nxt = S_SCAN;
        end else begin
          q_ra      = q_addr(qb_r, k_r - CW'(1));
          state_nxt = S_SHF_WR;
        end
      end

      S_SHF_WR: begin
        q_we      = 1'b1;
        q_wa      = q_addr(qb_r, k_r);
        q_wd      = q_rd;
        k_nxt     = k_r - CW'(1);
        state_nxt = S_SHF;
      end

      // run the queue head and reload its countdown, or report that none ran
      S_POP_RD: begin
        if (qlen_r == '0) begin
          ov_nxt = 1'b1; oran_nxt = 1'b0; oidx_nxt = '0; ofull_nxt = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          q_ra      = qb_r;
          state_nxt = S_POP_Q;
        end
      end

      S_POP_Q: begin
        s_nxt        = q_rd;
        per_ra       = q_rd;
        pend_nxt[q_rd] = 1'b0;
        qb_nxt       = q_addr(qb_r, CW'(1));
        qlen_nxt     = qlen_r - CW'(1);
        state_nxt    = S_POP_WR;
      end

      S_POP_WR: begin
        cnt_we    = 1'b1;
        cnt_wa    = s_r;
        cnt_wd    = per_rd;
        ov_nxt    = 1'b1;
        oran_nxt  = 1'b1;
        oidx_nxt  = IDX_W'(s_r);
        ofull_nxt = 1'b0;
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tiu_r   <= '0;
      qlen_r  <= '0;
      qb_r    <= '0;
      ov_r    <= 1'b0;
      for (int n = 0; n < MAX_TASKS; n++) begin
        due_r[n]  <= 1'b0;
        pend_r[n] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      tiu_r   <= tiu_nxt;
      qlen_r  <= qlen_nxt;
      qb_r    <= qb_nxt;
      ov_r    <= ov_nxt;
      due_r   <= due_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    per_r   <= per_nxt;
    preq_r  <= preq_nxt;
    i_r     <= i_nxt;
    pos_r   <= pos_nxt;
    k_r     <= k_nxt;
    s_r     <= s_nxt;
    spri_r  <= spri_nxt;
    oran_r  <= oran_nxt;
    oidx_r  <= oidx_nxt;
    ofull_r <= ofull_nxt;
  end

endmodule : periodic_priority_task_scheduler

`default_nettype wire
